[hdl/dfp_pkg.sv]
// Package for the decimal fixed-point multiply/divide unit.
// Widths, default scale and the record that travels down the divider chain.
// No dependencies.
package dfp_pkg;

    localparam int unsigned DFP_W  = 64;
    localparam int unsigned DFP_QW = 2 * DFP_W;
    localparam int unsigned DFP_SW = 32;

    localparam logic [DFP_SW-1:0] DFP_SCALE_DEF = 32'd1000000000;

    // operation codes
    localparam logic DFP_OP_MUL = 1'b0;
    localparam logic DFP_OP_DIV = 1'b1;

    // per-item flags that ride along with the data
    typedef struct packed {
        logic neg;
        logic dz;
    } t_side;

    // state held by one divider cell
    typedef struct packed {
        logic [DFP_W-1:0]  rem;
        logic [DFP_QW-1:0] num;
        logic [DFP_W-1:0]  den;
        t_side             side;
    } t_cell;

endpackage

[hdl/dfp_if.sv]
// Valid/ready channel interfaces for the decimal fixed-point unit.
// Depends on dfp_pkg.
interface dfp_req_if
    import dfp_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic signed [DFP_W-1:0] operand_a;
    logic signed [DFP_W-1:0] operand_b;

    modport source (output valid, op, operand_a, operand_b, input ready);
    modport sink   (input valid, op, operand_a, operand_b, output ready);
endinterface

interface dfp_rsp_if
    import dfp_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [DFP_W-1:0] result;
    logic                    overflow;
    logic                    divide_by_zero;

    modport source (output valid, result, overflow, divide_by_zero, input ready);
    modport sink   (input valid, result, overflow, divide_by_zero, output ready);
endinterface

[hdl/dfp_div_cell.sv]
// One restoring-division cell: produces one quotient bit per cell.
// Depends on dfp_pkg.
module dfp_div_cell
    import dfp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_cell i_data,
    output logic  o_valid,
    output t_cell o_data
);

    logic          r_valid;
    t_cell         r_data;
    t_cell         n_data;
    logic [DFP_W:0] w_trial;
    logic [DFP_W:0] w_diff;
    logic          w_ge;

    // shift next dividend bit into the partial remainder
    assign w_trial = {i_data.rem, i_data.num[DFP_QW-1]};
    assign w_diff  = w_trial - {1'b0, i_data.den};
    assign w_ge    = (w_trial >= {1'b0, i_data.den});

    always_comb begin
        n_data      = i_data;
        n_data.rem  = w_ge ? w_diff[DFP_W-1:0] : w_trial[DFP_W-1:0];
        n_data.num  = {i_data.num[DFP_QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[hdl/decimal_fixed_point_mul_div.sv]
// Top level of the signed 64-bit decimal fixed-point multiply/divide unit.
// Depends on dfp_pkg, dfp_req_if/dfp_rsp_if and dfp_div_cell.
//
// Values are integers scaled by SCALE. Both operations reduce to one
// truncating division of magnitudes: multiply gives |a|*|b| / SCALE, divide
// gives |a|*SCALE / |b|, which equals the whole-part/fraction-part formulas
// exactly. The sign of a xor b is applied last; the 128-bit signed result is
// returned as its low 64 bits with overflow set when it does not fit. Divide
// by zero returns 0 with divide_by_zero set. Throughput is one operation per
// cycle while the output register is empty or taken. The stages are the
// magnitudes, four 32x32 partial products, their sum, 128 restoring-division
// cells (one quotient bit each), and one output register that applies the sign.
// The whole pipeline advances while the output register is empty or taken.
module decimal_fixed_point_mul_div
    import dfp_pkg::*;
#(
    parameter logic [DFP_SW-1:0] SCALE = DFP_SCALE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dfp_req_if.sink      i_req,
    dfp_rsp_if.source    o_rsp
);

    localparam logic [DFP_W-1:0] SCALE_W = {{(DFP_W-DFP_SW){1'b0}}, SCALE};

    logic w_en;

    // stage 1: magnitudes and multiplier selection
    logic             r_v1;
    logic             r_op1;
    logic [DFP_W-1:0] r_ma1;
    logic [DFP_W-1:0] r_m1;
    logic [DFP_W-1:0] r_den1;
    t_side            r_side1;
    logic [DFP_W-1:0] w_ma;
    logic [DFP_W-1:0] w_mb;

    assign w_ma = i_req.operand_a[DFP_W-1] ? (~i_req.operand_a + 1'b1) : i_req.operand_a;
    assign w_mb = i_req.operand_b[DFP_W-1] ? (~i_req.operand_b + 1'b1) : i_req.operand_b;

    // stage 2: partial products
    logic              r_v2;
    logic [DFP_W-1:0]  r_pp_ll;
    logic [DFP_W-1:0]  r_pp_lh;
    logic [DFP_W-1:0]  r_pp_hl;
    logic [DFP_W-1:0]  r_pp_hh;
    logic [DFP_W-1:0]  r_den2;
    t_side             r_side2;

    // stage 3: full dividend
    logic              r_v3;
    t_cell             r_cell3;
    logic [DFP_QW-1:0] w_sum;

    assign w_sum = {{DFP_W{1'b0}}, r_pp_ll}
                 + {{DFP_SW{1'b0}}, r_pp_lh, {DFP_SW{1'b0}}}
                 + {{DFP_SW{1'b0}}, r_pp_hl, {DFP_SW{1'b0}}}
                 + {r_pp_hh, {DFP_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (w_en) begin
            r_op1        <= i_req.op;
            r_ma1        <= w_ma;
            // multiply: |a|*|b| / SCALE; divide: |a|*SCALE / |b|
            r_m1         <= (i_req.op == DFP_OP_DIV) ? SCALE_W : w_mb;
            r_den1       <= (i_req.op == DFP_OP_DIV) ? w_mb : SCALE_W;
            r_side1.neg  <= i_req.operand_a[DFP_W-1] ^ i_req.operand_b[DFP_W-1];
            r_side1.dz   <= (i_req.op == DFP_OP_DIV) && (w_mb == '0);

            r_pp_ll <= r_ma1[DFP_SW-1:0]     * r_m1[DFP_SW-1:0];
            r_pp_lh <= r_ma1[DFP_SW-1:0]     * r_m1[DFP_W-1:DFP_SW];
            r_pp_hl <= r_ma1[DFP_W-1:DFP_SW] * r_m1[DFP_SW-1:0];
            r_pp_hh <= r_ma1[DFP_W-1:DFP_SW] * r_m1[DFP_W-1:DFP_SW];
            r_den2  <= r_den1;
            r_side2 <= r_side1;

            r_cell3.rem  <= '0;
            r_cell3.num  <= w_sum;
            r_cell3.den  <= r_den2;
            r_cell3.side <= r_side2;
        end
    end

    // division chain, one quotient bit per cell, MSB first
    logic  w_cv [0:DFP_QW];
    t_cell w_cd [0:DFP_QW];

    assign w_cv[0] = r_v3;
    assign w_cd[0] = r_cell3;

    for (genvar g = 0; g < DFP_QW; g++) begin : g_cell
        dfp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cv[g]),
            .i_data  (w_cd[g]),
            .o_valid (w_cv[g+1]),
            .o_data  (w_cd[g+1])
        );
    end

    // output stage: sign, overflow, divide-by-zero
    logic              r_vo;
    logic [DFP_W-1:0]  r_res;
    logic              r_ovf;
    logic              r_dz;
    logic [DFP_QW-1:0] w_q;
    logic [DFP_QW-1:0] w_mag;
    logic              w_fits;

    assign w_q    = w_cd[DFP_QW].num;
    assign w_mag  = w_cd[DFP_QW].side.neg ? (~w_q + 1'b1) : w_q;
    assign w_fits = (w_mag[DFP_QW-1:DFP_W-1] == '0) || (&w_mag[DFP_QW-1:DFP_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_en) begin
            r_vo <= w_cv[DFP_QW];
        end
        if (w_en) begin
            r_dz  <= w_cd[DFP_QW].side.dz;
            r_res <= w_cd[DFP_QW].side.dz ? '0 : w_mag[DFP_W-1:0];
            r_ovf <= !w_cd[DFP_QW].side.dz && !w_fits;
        end
    end

    assign w_en        = !r_vo || o_rsp.ready;
    assign i_req.ready = w_en;

    assign o_rsp.valid          = r_vo;
    assign o_rsp.result         = r_res;
    assign o_rsp.overflow       = r_ovf;
    assign o_rsp.divide_by_zero = r_dz;

    // divide by zero always gives a clean zero result
    a_dz_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.divide_by_zero) |-> (o_rsp.result == '0 && !o_rsp.overflow))
        else $error("divide by zero result not cleared");

    // a multiply never carries the divide-by-zero flag
    a_mul_no_dz : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_op1 == DFP_OP_MUL) |-> !r_side1.dz)
        else $error("multiply flagged divide by zero");

    // pipeline empties on reset
    a_rst_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("output valid after reset");

endmodule
